### design/rgbled_pkg.sv
package rgbled_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned COLOR_W    = 24;
	localparam int unsigned BITS_W     = 5;
	localparam int unsigned TICK_W     = 16;

	localparam logic [BITS_W-1:0] BITS_PER_PIXEL = 5'd24;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

	localparam logic [7:0]        RST_ZERO_HIGH = 8'd18;
	localparam logic [7:0]        RST_ZERO_LOW  = 8'd40;
	localparam logic [7:0]        RST_ONE_HIGH  = 8'd35;
	localparam logic [7:0]        RST_ONE_LOW   = 8'd30;
	localparam logic [TICK_W-1:0] RST_LATCH     = 16'd2600;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2,
		PH_LATCH = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]        zero_high;
		logic [7:0]        zero_low;
		logic [7:0]        one_high;
		logic [7:0]        one_low;
		logic [TICK_W-1:0] latch;
	} cfg_t;

	typedef struct packed {
		logic line_level;
		logic ready_res;
		logic accepted;
		logic frame_done;
	} res_t;

	// a zero count still lasts one tick
	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

endpackage

### design/rgbled_cfg_regs.sv
module rgbled_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rgbled_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgbled_pkg::CFG_DATA_W-1:0]    cfg_data,
	output rgbled_pkg::cfg_t                     cfg
);

	rgbled_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high <= rgbled_pkg::RST_ZERO_HIGH;
			cfg_q.zero_low  <= rgbled_pkg::RST_ZERO_LOW;
			cfg_q.one_high  <= rgbled_pkg::RST_ONE_HIGH;
			cfg_q.one_low   <= rgbled_pkg::RST_ONE_LOW;
			cfg_q.latch     <= rgbled_pkg::RST_LATCH;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbled_pkg::REG_ZERO_HIGH: cfg_q.zero_high <= cfg_data[7:0];
				rgbled_pkg::REG_ZERO_LOW:  cfg_q.zero_low  <= cfg_data[7:0];
				rgbled_pkg::REG_ONE_HIGH:  cfg_q.one_high  <= cfg_data[7:0];
				rgbled_pkg::REG_ONE_LOW:   cfg_q.one_low   <= cfg_data[7:0];
				rgbled_pkg::REG_LATCH:     cfg_q.latch     <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/rgbled_core.sv
module rgbled_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                req_type,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic                end_of_frame,
	input  rgbled_pkg::cfg_t    cfg,
	output rgbled_pkg::res_t    res
);

	rgbled_pkg::phase_t                    phase_q, phase_d;
	logic [rgbled_pkg::COLOR_W-1:0]        color_shift_q, color_shift_d;
	logic [rgbled_pkg::BITS_W-1:0]         bits_left_q, bits_left_d;
	logic [rgbled_pkg::TICK_W-1:0]         tick_count_q, tick_count_d;
	logic                                  latch_pending_q, latch_pending_d;

	logic [rgbled_pkg::TICK_W-1:0]         tick_dec;
	logic [rgbled_pkg::COLOR_W-1:0]        shifted;
	logic [rgbled_pkg::BITS_W-1:0]         bits_dec;
	logic [rgbled_pkg::COLOR_W-1:0]        new_color;
	logic [rgbled_pkg::TICK_W-1:0]         high_new, high_shifted, low_cur;
	logic                                  accepted, done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= rgbled_pkg::PH_IDLE;
			color_shift_q   <= '0;
			bits_left_q     <= '0;
			tick_count_q    <= '0;
			latch_pending_q <= 1'b0;
		end else if (fire) begin
			phase_q         <= phase_d;
			color_shift_q   <= color_shift_d;
			bits_left_q     <= bits_left_d;
			tick_count_q    <= tick_count_d;
			latch_pending_q <= latch_pending_d;
		end
	end

	always_comb begin
		tick_dec  = (tick_count_q != '0) ? tick_count_q - rgbled_pkg::TICK_W'(1) : '0;
		shifted   = {color_shift_q[rgbled_pkg::COLOR_W-2:0], 1'b0};
		bits_dec  = (bits_left_q != '0) ? bits_left_q - rgbled_pkg::BITS_W'(1) : '0;
		new_color = {green, red, blue};

		high_new     = rgbled_pkg::at_least_one(rgbled_pkg::TICK_W'(
			new_color[rgbled_pkg::COLOR_W-1] ? cfg.one_high : cfg.zero_high));
		high_shifted = rgbled_pkg::at_least_one(rgbled_pkg::TICK_W'(
			shifted[rgbled_pkg::COLOR_W-1] ? cfg.one_high : cfg.zero_high));
		low_cur      = rgbled_pkg::at_least_one(rgbled_pkg::TICK_W'(
			color_shift_q[rgbled_pkg::COLOR_W-1] ? cfg.one_low : cfg.zero_low));

		phase_d         = phase_q;
		color_shift_d   = color_shift_q;
		bits_left_d     = bits_left_q;
		tick_count_d    = tick_count_q;
		latch_pending_d = latch_pending_q;
		accepted        = 1'b0;
		done            = 1'b0;

		if (!req_type) begin
			if (phase_q == rgbled_pkg::PH_IDLE) begin
				color_shift_d   = new_color;
				bits_left_d     = rgbled_pkg::BITS_PER_PIXEL;
				latch_pending_d = end_of_frame;
				phase_d         = rgbled_pkg::PH_HIGH;
				tick_count_d    = high_new;
				accepted        = 1'b1;
			end
		end else if (phase_q != rgbled_pkg::PH_IDLE) begin
			tick_count_d = tick_dec;
			if (tick_dec == '0) begin
				case (phase_q)
					rgbled_pkg::PH_HIGH: begin
						phase_d      = rgbled_pkg::PH_LOW;
						tick_count_d = low_cur;
					end
					rgbled_pkg::PH_LOW: begin
						color_shift_d = shifted;
						bits_left_d   = bits_dec;
						if (bits_dec != '0) begin
							phase_d      = rgbled_pkg::PH_HIGH;
							tick_count_d = high_shifted;
						end else if (latch_pending_q) begin
							latch_pending_d = 1'b0;
							phase_d         = rgbled_pkg::PH_LATCH;
							tick_count_d    = rgbled_pkg::at_least_one(cfg.latch);
						end else begin
							phase_d = rgbled_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_d = rgbled_pkg::PH_IDLE;
						done    = 1'b1;
					end
				endcase
			end
		end

		res.line_level = (phase_d == rgbled_pkg::PH_HIGH);
		res.ready_res  = (phase_d == rgbled_pkg::PH_IDLE);
		res.accepted   = accepted;
		res.frame_done = done;
	end

endmodule

### design/rgb_led_one_wire_serializer_unit.sv
// One-wire RGB LED serializer: pixel and tick items in, one line-state result per item.
// An input transfer passes through the input register, then the result register, which drives the output.
// Throughput: one item per cycle while out_stall is low; the state update is a single
// pass of logic between the input register and the result register.
// Reset (arst_n low, asynchronous): pipeline empty, serializer phase idle, timing
// registers back to their defaults.
module rgb_led_one_wire_serializer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [7:0]                         red,
	input  logic [7:0]                         green,
	input  logic [7:0]                         blue,
	input  logic                               end_of_frame,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               line_level,
	output logic                               ready_res,
	output logic                               accepted,
	output logic                               frame_done,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [rgbled_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rgbled_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// input register (stage 1)
	logic       valid_s1;
	logic       req_type_s1;
	logic [7:0] red_s1, green_s1, blue_s1;
	logic       eof_s1;

	// result register (stage 2)
	logic             valid_s2;
	rgbled_pkg::res_t res_s2;

	rgbled_pkg::cfg_t cfg;
	rgbled_pkg::res_t res;

	logic advance;   // result register free to take a new result
	logic fire;      // stage 1 item is processed this cycle
	logic in_xfer;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// Control for stage 1: hold the item while the result side is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of stage 1 needs no reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_type_s1 <= req_type;
			red_s1      <= red;
			green_s1    <= green;
			blue_s1     <= blue;
			eof_s1      <= end_of_frame;
		end
	end

	rgbled_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Serializer state and next-state logic; state advances only on fire.
	rgbled_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.req_type     (req_type_s1),
		.red          (red_s1),
		.green        (green_s1),
		.blue         (blue_s1),
		.end_of_frame (eof_s1),
		.cfg          (cfg),
		.res          (res)
	);

	// Result register: load on fire, hold while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign line_level = res_s2.line_level;
	assign ready_res  = res_s2.ready_res;
	assign accepted   = res_s2.accepted;
	assign frame_done = res_s2.frame_done;

endmodule

### design/rgbled_checker.sv
module rgbled_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic line_level,
	input logic ready_res,
	input logic accepted,
	input logic frame_done
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(line_level) && $stable(ready_res)
			&& $stable(accepted) && $stable(frame_done))
		else $error("stalled result changed");

	// a taken pixel starts its first high pulse at once
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> line_level && !ready_res && !frame_done)
		else $error("accepted pixel did not start a high pulse");

	// end of latch leaves the line idle low
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> ready_res && !line_level && !accepted)
		else $error("frame_done outside idle");

	// line high only while busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_level |-> !ready_res)
		else $error("line high while ready");

endmodule

bind rgb_led_one_wire_serializer_unit rgbled_checker u_rgbled_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.line_level (line_level),
	.ready_res  (ready_res),
	.accepted   (accepted),
	.frame_done (frame_done)
);

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	// item kinds on req_type
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// indexes past the last register; writes there must change nothing
	localparam logic [rgbled_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [rgbled_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// longest quiet stretch is the receiver hold-off plus a few register writes
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              in_valid     = 1'b0;
	logic                              in_stall;
	logic                              req_type     = REQ_TICK;
	logic [7:0]                        red          = '0;
	logic [7:0]                        green        = '0;
	logic [7:0]                        blue         = '0;
	logic                              end_of_frame = 1'b0;
	logic                              out_valid;
	logic                              out_stall    = 1'b0;
	logic                              line_level;
	logic                              ready_res;
	logic                              accepted;
	logic                              frame_done;
	logic                              cfg_we       = 1'b0;
	logic [rgbled_pkg::CFG_IDX_W-1:0]  cfg_index    = rgbled_pkg::REG_ZERO_HIGH;
	logic [rgbled_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// line model: timing registers and serializer state
	rgbled_pkg::cfg_t   line_cfg;
	rgbled_pkg::phase_t line_phase;
	logic [23:0]        px_bits;
	logic [4:0]         bits_todo;
	logic [15:0]        phase_ticks;
	logic               latch_owed;

	rgbled_pkg::res_t line_expect[$];
	int   mismatch_count = 0;
	int   items_offered  = 0;
	int   quiet_cycles   = 0;
	bit   tx_pause_on    = 1'b0;
	bit   rx_pause_on    = 1'b0;
	int   rx_burst_left  = 0;
	int   rx_hold_left   = 0;

	rgb_led_one_wire_serializer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_level   (line_level),
		.ready_res    (ready_res),
		.accepted     (accepted),
		.frame_done   (frame_done),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Line model
	// ------------------------------------------------------------------

	// a programmed count of zero still lasts one tick
	function automatic logic [15:0] min_one(input logic [15:0] v);
		return v | 16'(v == '0);
	endfunction

	function automatic void open_high();
		line_phase  = rgbled_pkg::PH_HIGH;
		phase_ticks = min_one(px_bits[23] ? 16'(line_cfg.one_high) : 16'(line_cfg.zero_high));
	endfunction

	function automatic void open_low();
		line_phase  = rgbled_pkg::PH_LOW;
		phase_ticks = min_one(px_bits[23] ? 16'(line_cfg.one_low) : 16'(line_cfg.zero_low));
	endfunction

	// Advance the line model by one transfer and return the line state it leaves.
	function automatic rgbled_pkg::res_t predict_line(input logic req, input logic [7:0] r, g, b,
			input logic eof);
		rgbled_pkg::res_t res;
		res = '0;
		if (req == REQ_PIXEL) begin
			// a pixel only lands while the line is idle; otherwise drop it
			if (line_phase == rgbled_pkg::PH_IDLE) begin
				px_bits      = {g, r, b};
				bits_todo    = rgbled_pkg::BITS_PER_PIXEL;
				latch_owed   = eof;
				res.accepted = 1'b1;
				open_high();
			end
		end else if (line_phase != rgbled_pkg::PH_IDLE) begin
			if (phase_ticks != '0)
				phase_ticks--;
			if (phase_ticks == '0) begin
				case (line_phase)
					rgbled_pkg::PH_HIGH: open_low();
					rgbled_pkg::PH_LOW: begin
						// bit finished: shift in the next one, or close the pixel
						px_bits = px_bits << 1;
						if (bits_todo != '0)
							bits_todo--;
						if (bits_todo != '0)
							open_high();
						else if (latch_owed) begin
							latch_owed  = 1'b0;
							line_phase  = rgbled_pkg::PH_LATCH;
							phase_ticks = min_one(line_cfg.latch);
						end else
							line_phase = rgbled_pkg::PH_IDLE;
					end
					default: begin
						line_phase     = rgbled_pkg::PH_IDLE;
						res.frame_done = 1'b1;
					end
				endcase
			end
		end
		res.line_level = (line_phase == rgbled_pkg::PH_HIGH);
		res.ready_res  = (line_phase == rgbled_pkg::PH_IDLE);
		return res;
	endfunction

	// ticks a whole pixel takes from an idle line under the current timing
	function automatic int frame_ticks(input logic [23:0] color, input logic eof);
		int n;
		n = 0;
		for (int i = 0; i < 24; i++)
			n += color[i]
				? int'(min_one(16'(line_cfg.one_high))) + int'(min_one(16'(line_cfg.one_low)))
				: int'(min_one(16'(line_cfg.zero_high))) + int'(min_one(16'(line_cfg.zero_low)));
		if (eof)
			n += int'(min_one(line_cfg.latch));
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Monitors: input transfers feed the model, output transfers are checked
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			line_expect.push_back(predict_line(req_type, red, green, blue, end_of_frame));
	end

	function automatic void check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		rgbled_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (line_expect.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with nothing expected, actual %b%b%b%b", $time,
					line_level, ready_res, accepted, frame_done);
			end else begin
				want = line_expect.pop_front();
				check_field("line_level", want.line_level, line_level);
				check_field("ready_res", want.ready_res, ready_res);
				check_field("accepted", want.accepted, accepted);
				check_field("frame_done", want.frame_done, frame_done);
			end
		end
	end

	// Receiver: a long hold-off when asked, else random stall bursts.
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_stall <= 1'b1;
		end else if (rx_burst_left > 0) begin
			rx_burst_left--;
			out_stall <= 1'b1;
		end else if (rx_pause_on && $urandom_range(0, 15) == 0) begin
			rx_burst_left = int'($urandom_range(0, 16));
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// Watchdog: give up when neither channel moves a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one item and hold it until the transfer; maybe idle first.
	task automatic send_item(input logic req, input logic [7:0] r, g, b, input logic eof);
		int gap;
		if (tx_pause_on && $urandom_range(0, 5) == 0) begin
			gap = int'($urandom_range(1, 17));
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= req;
		red          <= r;
		green        <= g;
		blue         <= b;
		end_of_frame <= eof;
		items_offered++;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// a tick carries random junk in the pixel fields
	task automatic send_tick();
		send_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// Send a pixel and the ticks that carry it out; extra trims or pads the tick count.
	task automatic run_pixel(input logic [7:0] r, g, b, input logic eof, input int extra);
		int n;
		n = frame_ticks({g, r, b}, eof) + extra;
		send_item(REQ_PIXEL, r, g, b, eof);
		if (n > 0)
			repeat (n) send_tick();
	endtask

	// Drop valid and wait for every result to come back, then let the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (line_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rgbled_pkg::CFG_IDX_W-1:0] idx,
			input logic [rgbled_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rgbled_pkg::REG_ZERO_HIGH: line_cfg.zero_high = val[7:0];
			rgbled_pkg::REG_ZERO_LOW:  line_cfg.zero_low  = val[7:0];
			rgbled_pkg::REG_ONE_HIGH:  line_cfg.one_high  = val[7:0];
			rgbled_pkg::REG_ONE_LOW:   line_cfg.one_low   = val[7:0];
			rgbled_pkg::REG_LATCH:     line_cfg.latch     = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Reprogram all five timing registers once the pipeline is empty.
	task automatic set_timing(input logic [15:0] zh, zl, oh, ol, lt);
		drain();
		write_reg(rgbled_pkg::REG_ZERO_HIGH, zh);
		write_reg(rgbled_pkg::REG_ZERO_LOW, zl);
		write_reg(rgbled_pkg::REG_ONE_HIGH, oh);
		write_reg(rgbled_pkg::REG_ONE_LOW, ol);
		write_reg(rgbled_pkg::REG_LATCH, lt);
	endtask

	// Tick in small batches until the model says the line is back to idle.
	task automatic tick_until_idle();
		drain();
		while (line_phase != rgbled_pkg::PH_IDLE) begin
			repeat (8) send_tick();
			drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Ticks on an idle line, then the first bits of a framed pixel under the reset timing.
	task automatic test_reset_values();
		tx_pause_on = 1'b1;
		rx_pause_on = 1'b1;
		repeat (3) send_tick();
		// green A5 leads with a one bit (35 high, 30 low), then a zero bit (18 high, 40 low)
		send_item(REQ_PIXEL, 8'h12, 8'hA5, 8'h3C, 1'b1);
		repeat (125) send_tick();
		// shorten every count so the rest of the pixel and its latch finish quickly
		set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
		tick_until_idle();
	endtask

	// Pixels offered in the low phase and in the latch get dropped.
	task automatic test_busy_drop();
		int n;
		set_timing(16'd2, 16'd3, 16'd3, 16'd2, 16'd5);
		n = frame_ticks({8'h00, 8'hC3, 8'h3C}, 1'b1);
		// green leads with a zero bit: two ticks high, then low
		send_item(REQ_PIXEL, 8'hC3, 8'h00, 8'h3C, 1'b1);
		repeat (2) send_tick();
		send_item(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		// stop two ticks short of the latch end
		repeat (n - 4) send_tick();
		send_item(REQ_PIXEL, 8'h81, 8'h7E, 8'h18, 1'b1);
		repeat (3) send_tick();
	endtask

	// Registers rewritten while a bit or a latch is running: the running phase keeps its count.
	task automatic test_midphase_write();
		set_timing(16'd4, 16'd4, 16'd4, 16'd4, 16'd3);
		send_item(REQ_PIXEL, 8'h5A, 8'hF0, 8'h0F, 1'b1);
		repeat (6) send_tick();
		set_timing(16'd1, 16'd2, 16'd3, 16'd1, 16'd2);
		tick_until_idle();
		send_item(REQ_PIXEL, 8'h00, 8'h01, 8'hFE, 1'b1);
		repeat (frame_ticks({8'h01, 8'h00, 8'hFE}, 1'b1) - 1) send_tick();
		set_timing(16'd2, 16'd2, 16'd2, 16'd2, 16'd9);
		tick_until_idle();
	endtask

	// Widest count, zero counts, masked upper bits, spare indexes.
	task automatic test_timing_extremes();
		tx_pause_on = 1'b0;
		rx_pause_on = 1'b0;
		// only the last bit is a zero: one long high pulse after 23 short bits
		set_timing(16'd255, 16'd1, 16'd1, 16'd1, 16'd1);
		run_pixel(8'hFF, 8'hFF, 8'hFE, 1'b1, 0);
		// upper byte set, low byte zero: every count collapses to one tick
		set_timing(16'hFF00, 16'h0100, 16'hAB00, 16'h0000, 16'h0000);
		run_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
		drain();
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h0001);
		run_pixel(8'h80, 8'h01, 8'h40, 1'b1, 0);
		set_timing(16'h7F01, 16'h8002, 16'h0103, 16'hFE01, 16'h0003);
		run_pixel(8'hFF, 8'h00, 8'hFF, 1'b1, 1);
		drain();
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering ticks.
	task automatic test_backpressure();
		set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		rx_hold_left = HOLD_CYCLES;
		run_pixel(8'hE7, 8'h18, 8'h99, 1'b1, 8);
		drain();
	endtask

	// Random frames under random small timing; some cut short, some padded, some noise.
	task automatic test_random();
		logic [23:0] color;
		int          extra;
		int          stop_at;
		stop_at     = items_offered + 250;
		tx_pause_on = 1'b1;
		rx_pause_on = 1'b1;
		while (items_offered < stop_at) begin
			set_timing({8'($urandom), 8'($urandom_range(0, 3))},
				{8'($urandom), 8'($urandom_range(0, 3))},
				{8'($urandom), 8'($urandom_range(0, 3))},
				{8'($urandom), 8'($urandom_range(0, 3))},
				16'($urandom_range(0, 12)));
			repeat ($urandom_range(1, 3)) begin
				// run the tail of the stimulus with no idling at all
				if (stop_at - items_offered < 80) begin
					tx_pause_on = 1'b0;
					rx_pause_on = 1'b0;
				end
				color = 24'($urandom);
				case ($urandom_range(0, 9))
					0: extra = -int'($urandom_range(1, 40));
					1: extra = int'($urandom_range(1, 6));
					default: extra = 0;
				endcase
				run_pixel(color[23:16], color[15:8], color[7:0], 1'($urandom), extra);
				if ($urandom_range(0, 7) == 0)
					send_item(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom));
			end
		end
		tx_pause_on = 1'b0;
		rx_pause_on = 1'b0;
	endtask

	initial begin
		// model state after reset
		line_cfg    = '{rgbled_pkg::RST_ZERO_HIGH, rgbled_pkg::RST_ZERO_LOW,
			rgbled_pkg::RST_ONE_HIGH, rgbled_pkg::RST_ONE_LOW, rgbled_pkg::RST_LATCH};
		line_phase  = rgbled_pkg::PH_IDLE;
		px_bits     = '0;
		bits_todo   = '0;
		phase_ticks = '0;
		latch_owed  = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_busy_drop();
		test_midphase_write();
		test_timing_extremes();
		test_backpressure();
		test_random();

		drain();
		repeat (8) @(posedge clk);
		if (line_expect.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d results never arrived", $time, line_expect.size());
		end
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
